@@ rtl/core/cbrm_pkg.sv @@
// Shared types and constants for the CAN bus-off recovery manager.
`default_nettype none

package cbrm_pkg;

    localparam int unsigned TIMER_W = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    localparam logic [TIMER_W-1:0] STARTUP_TICKS_RST = 16'd10;
    localparam logic [TIMER_W-1:0] QUICK_TICKS_RST = 16'd10;
    localparam logic [TIMER_W-1:0] SLOW_TICKS_RST = 16'd100;
    localparam logic [COUNT_W-1:0] QUICK_LIMIT_RST = 8'd6;

    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUICK_TICKS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_TICKS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUICK_LIMIT = 8'd3;

    typedef struct packed {
        logic busoff_seen;
        logic tx_confirmed;
    } t_tick;

    typedef struct packed {
        logic               send_frame;
        logic               busoff_notice;
        logic               controller_reinit;
        logic               busoff_end_notice;
        logic               recovery_success;
        logic               in_busoff;
        logic [COUNT_W-1:0] busoff_total;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/cbrm_if.sv @@
// Handshake interfaces for tick input, result output and register writes.
`default_nettype none

interface cbrm_in_if;
    logic valid;
    logic ready;
    logic busoff_seen;
    logic tx_confirmed;

    modport source (output valid, output busoff_seen, output tx_confirmed, input ready);
    modport sink (input valid, input busoff_seen, input tx_confirmed, output ready);
endinterface

interface cbrm_out_if;
    logic       valid;
    logic       ready;
    logic       send_frame;
    logic       busoff_notice;
    logic       controller_reinit;
    logic       busoff_end_notice;
    logic       recovery_success;
    logic       in_busoff;
    logic [7:0] busoff_total;

    modport source (output valid, output send_frame, output busoff_notice,
                    output controller_reinit, output busoff_end_notice,
                    output recovery_success, output in_busoff, output busoff_total,
                    input ready);
    modport sink (input valid, input send_frame, input busoff_notice,
                  input controller_reinit, input busoff_end_notice,
                  input recovery_success, input in_busoff, input busoff_total,
                  output ready);
endinterface

interface cbrm_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cbrm_input_stage.sv @@
// Input register that captures one tick transaction.
`default_nettype none

module cbrm_input_stage (
    input  wire            i_clk,
    input  wire            i_rst_n,
    cbrm_in_if.sink        i_item,
    input  wire            i_advance,
    output logic           o_valid,
    output cbrm_pkg::t_tick o_tick
);
    import cbrm_pkg::*;

    logic  r_valid;
    t_tick r_tick;

    assign i_item.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_tick.busoff_seen  <= i_item.busoff_seen;
            r_tick.tx_confirmed <= i_item.tx_confirmed;
        end
    end

    assign o_valid = r_valid;
    assign o_tick  = r_tick;

endmodule

`default_nettype wire

@@ rtl/core/cbrm_tick_core.sv @@
// Configuration registers, recovery state and the per-tick update logic.
`default_nettype none

module cbrm_tick_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    cbrm_cfg_if.sink          i_cfg,
    input  wire               i_advance,
    input  cbrm_pkg::t_tick   i_tick,
    output cbrm_pkg::t_result o_result
);
    import cbrm_pkg::*;

    logic [TIMER_W-1:0] r_startup_ticks;
    logic [TIMER_W-1:0] r_quick_ticks;
    logic [TIMER_W-1:0] r_slow_ticks;
    logic [COUNT_W-1:0] r_quick_limit;

    logic [TIMER_W-1:0] r_startup_timer, n_startup_timer;
    logic [TIMER_W-1:0] r_recover_timer, n_recover_timer;
    logic               r_off_flag, n_off_flag;
    logic [COUNT_W-1:0] r_off_count, n_off_count;
    logic               r_pend_busoff, n_pend_busoff;
    logic               r_pend_confirm, n_pend_confirm;
    logic               r_ticked;

    logic cfg_write;

    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup_ticks <= STARTUP_TICKS_RST;
            r_quick_ticks   <= QUICK_TICKS_RST;
            r_slow_ticks    <= SLOW_TICKS_RST;
            r_quick_limit   <= QUICK_LIMIT_RST;
        end else if (cfg_write) begin
            case (i_cfg.index)
                REG_STARTUP_TICKS: r_startup_ticks <= i_cfg.data;
                REG_QUICK_TICKS:   r_quick_ticks   <= i_cfg.data;
                REG_SLOW_TICKS:    r_slow_ticks    <= i_cfg.data;
                REG_QUICK_LIMIT:   r_quick_limit   <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_startup_timer = r_startup_timer;
        n_recover_timer = r_recover_timer;
        n_off_flag      = r_off_flag;
        n_off_count     = r_off_count;
        n_pend_busoff   = r_pend_busoff || i_tick.busoff_seen;
        n_pend_confirm  = r_pend_confirm || i_tick.tx_confirmed;
        o_result        = '0;

        if (r_startup_timer != '0) begin
            n_startup_timer     = r_startup_timer - 1'b1;
            o_result.send_frame = (n_startup_timer == '0);
        end else begin
            // recovery countdown
            if (r_off_flag) begin
                if (r_recover_timer != '0) begin
                    n_recover_timer = r_recover_timer - 1'b1;
                end
                if (n_recover_timer == '0) begin
                    o_result.send_frame        = 1'b1;
                    o_result.busoff_end_notice = 1'b1;
                    n_off_flag                 = 1'b0;
                end
            end
            // bus-off entry
            if (n_pend_busoff) begin
                n_pend_busoff = 1'b0;
                n_off_flag    = 1'b1;
                if (r_off_count != COUNT_MAX) begin
                    n_off_count = r_off_count + 1'b1;
                end
                o_result.busoff_notice     = 1'b1;
                o_result.controller_reinit = 1'b1;
                n_recover_timer = (n_off_count < r_quick_limit) ? r_quick_ticks
                                                                : r_slow_ticks;
            end
            // transmit confirm clears the count
            if (n_pend_confirm) begin
                n_pend_confirm = 1'b0;
                if (n_off_count != '0) begin
                    n_off_count               = '0;
                    o_result.recovery_success = 1'b1;
                end
            end
        end

        o_result.in_busoff    = n_off_flag;
        o_result.busoff_total = n_off_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup_timer <= STARTUP_TICKS_RST;
            r_recover_timer <= '0;
            r_off_flag      <= 1'b0;
            r_off_count     <= '0;
            r_pend_busoff   <= 1'b0;
            r_pend_confirm  <= 1'b0;
            r_ticked        <= 1'b0;
        end else if (i_advance) begin
            r_startup_timer <= n_startup_timer;
            r_recover_timer <= n_recover_timer;
            r_off_flag      <= n_off_flag;
            r_off_count     <= n_off_count;
            r_pend_busoff   <= n_pend_busoff;
            r_pend_confirm  <= n_pend_confirm;
            r_ticked        <= 1'b1;
        end else if (cfg_write && i_cfg.index == REG_STARTUP_TICKS && !r_ticked) begin
            r_startup_timer <= i_cfg.data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cbrm_result_stage.sv @@
// Result register that holds one result transaction until it is taken.
`default_nettype none

module cbrm_result_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  cbrm_pkg::t_result i_result,
    cbrm_out_if.source        o_result,
    output logic              o_free
);
    import cbrm_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid             = r_valid;
    assign o_result.send_frame        = r_result.send_frame;
    assign o_result.busoff_notice     = r_result.busoff_notice;
    assign o_result.controller_reinit = r_result.controller_reinit;
    assign o_result.busoff_end_notice = r_result.busoff_end_notice;
    assign o_result.recovery_success  = r_result.recovery_success;
    assign o_result.in_busoff         = r_result.in_busoff;
    assign o_result.busoff_total      = r_result.busoff_total;

endmodule

`default_nettype wire

@@ rtl/core/can_busoff_recovery_manager_unit.sv @@
// Top level of the CAN bus-off recovery manager.
// Takes one main-function tick per clock cycle while the result output is not stalled and
// returns one result per tick: the tick is held in the input register, then the state
// update loads the result register. The tick input stays ready while the result register is
// empty or being drained, and the input register holds one more tick while a result waits.
// Register writes are taken every cycle and should be issued only while no tick is in flight.
`default_nettype none

module can_busoff_recovery_manager_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cbrm_in_if.sink    i_item,
    cbrm_cfg_if.sink   i_cfg,
    cbrm_out_if.source o_result
);
    import cbrm_pkg::*;

    logic    tick_valid;
    t_tick   tick;
    t_result result;
    logic    out_free;
    logic    advance;

    assign advance = tick_valid && out_free;

    cbrm_input_stage u_input (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (advance),
        .o_valid   (tick_valid),
        .o_tick    (tick)
    );

    cbrm_tick_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_advance (advance),
        .i_tick    (tick),
        .o_result  (result)
    );

    cbrm_result_stage u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (result),
        .o_result (o_result),
        .o_free   (out_free)
    );

endmodule

`default_nettype wire

@@ rtl/core/cbrm_checker.sv @@
// Port-level assertions for the CAN bus-off recovery manager and their bind.
`default_nettype none

module cbrm_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_send_frame,
    input wire       i_busoff_notice,
    input wire       i_controller_reinit,
    input wire       i_busoff_end_notice,
    input wire       i_recovery_success,
    input wire       i_in_busoff,
    input wire [7:0] i_busoff_total
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_send_frame,
            i_busoff_notice, i_controller_reinit, i_busoff_end_notice,
            i_recovery_success, i_in_busoff, i_busoff_total}))
        else $error("stalled result changed");

    a_notice_enters_busoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_busoff_notice |-> i_in_busoff && i_controller_reinit
            && i_busoff_total != 8'd0 || i_out_valid && i_busoff_notice && i_recovery_success)
        else $error("bus-off notice without bus-off entry");

    a_end_sends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_busoff_end_notice |-> i_send_frame)
        else $error("recovery end without frame");

    a_success_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_recovery_success |-> i_busoff_total == 8'd0)
        else $error("recovery success with nonzero count");

endmodule

bind can_busoff_recovery_manager_unit cbrm_checker u_cbrm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_result.valid),
    .i_out_ready         (o_result.ready),
    .i_send_frame        (o_result.send_frame),
    .i_busoff_notice     (o_result.busoff_notice),
    .i_controller_reinit (o_result.controller_reinit),
    .i_busoff_end_notice (o_result.busoff_end_notice),
    .i_recovery_success  (o_result.recovery_success),
    .i_in_busoff         (o_result.in_busoff),
    .i_busoff_total      (o_result.busoff_total)
);

`default_nettype wire
